// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker of the queue (spq_checker).
// Needs no other file; include by bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge, disabled while reset is asserted.
`define SPQ_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("queue check failed");

// Check an implication whose consequent is checked in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("queue check failed");

`endif

// ===== rtl/spq_pkg.sv =====
// Shared types and constants of the sorted priority queue.
// Used by spq_cell, sorted_priority_queue_top and spq_checker; depends on nothing.
package spq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_REMOVE  = 2'd1,
		CMD_REORDER = 2'd2
	} cmd_t;

	typedef struct packed {
		logic        [15:0] id;
		logic        [15:0] arrival;
		logic        [15:0] burst;
		logic signed [31:0] prio;
	} slot_t;

	// Per-transaction control broadcast to every cell.
	typedef struct packed {
		logic  insert_en;
		logic  remove_en;
		slot_t new_slot;
	} cell_ctl_t;

endpackage

// ===== rtl/spq_cell.sv =====
// One slot of the sorted queue chain: holds an entry and trades it with its neighbors.
// Depends on spq_pkg.
module spq_cell (
	input  logic              clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  logic              occupied,
	input  logic              at_tail,
	input  logic              prev_greater,
	input  spq_pkg::slot_t    prev_slot,
	input  spq_pkg::slot_t    next_slot,
	output logic              new_greater,
	output spq_pkg::slot_t    slot_q,
	output spq_pkg::slot_t    slot_d
);

	logic pri_gt;
	logic take_slot;

	assign pri_gt      = ctl.new_slot.prio > slot_q.prio;
	assign new_greater = occupied && pri_gt;
	// Open this slot when the new entry outranks it, or when it is the first free one.
	assign take_slot   = occupied ? pri_gt : at_tail;

	always_comb begin
		slot_d = slot_q;
		if (ctl.insert_en && take_slot) begin
			// Shift the front neighbor back if it is also outranked, else land here.
			slot_d = prev_greater ? prev_slot : ctl.new_slot;
		end else if (ctl.remove_en) begin
			slot_d = next_slot;
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_d;
	end

endmodule

// ===== rtl/sorted_priority_queue_top.sv =====
// Top level of the sorted priority queue: command channel, result channel, cell chain.
// Depends on spq_pkg and spq_cell.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transaction:
//   insert an entry, remove the head, or run a reorder pass. Output channel
//   (out_valid/out_ready) returns one result per command: the head entry,
//   the entry count, the empty flag and whether the command took effect.
//   The result is valid in the cycle after the command transaction.
//   Throughput: one command per cycle while results are taken; the whole chain of DEPTH cells updates
//   in that single cycle, each cell comparing its own priority with the new
//   entry and taking data from a neighbor, so no loop spans the queue.
//   The result register is the only buffer: while a result waits on a
//   stalled receiver, in_ready is low; it rises in the cycle the result is
//   taken, so a new command may enter on the same edge.
//   Reset (arst_n low) empties the queue and drops any pending result; no
//   clearing pass is needed, since only slots below the count are read.
//   Entries stay sorted by priority, highest at the head, with equal
//   priorities in insertion order; a reorder pass therefore finds no pair
//   to swap and leaves the chain as is, reporting accepted.
module sorted_priority_queue_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic        [1:0]  cmd,
	input  logic        [15:0] task_id,
	input  logic        [15:0] task_arrival,
	input  logic        [15:0] task_burst,
	input  logic signed [31:0] priority_req,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [15:0] head_id,
	output logic        [15:0] head_arrival,
	output logic        [15:0] head_burst,
	output logic signed [31:0] head_priority,
	output logic        [4:0]  entry_count,
	output logic               queue_empty,
	output logic               accepted
);

	localparam int D = spq_pkg::DEPTH;
	localparam int W = spq_pkg::CNT_W;

	logic [W-1:0]        occ_q;
	logic [W-1:0]        occ_d;
	logic                out_valid_q;
	logic                in_fire;
	logic                full;
	logic                empty;
	logic                is_insert;
	logic                is_remove;
	logic                is_reorder;
	logic                ok;
	spq_pkg::cell_ctl_t  ctl;
	spq_pkg::slot_t      head_q;
	logic [4:0]          count_q;
	logic                empty_q;
	logic                ok_q;

	spq_pkg::slot_t      cell_q [D];
	spq_pkg::slot_t      cell_d [D];
	logic                cell_gt [D];

	// Accept a new transaction when the result register is free or being drained.
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign full       = occ_q == W'(D);
	assign empty      = occ_q == '0;
	assign is_insert  = cmd == spq_pkg::CMD_INSERT;
	assign is_remove  = cmd == spq_pkg::CMD_REMOVE;
	assign is_reorder = cmd == spq_pkg::CMD_REORDER;

	always_comb begin
		ctl.new_slot.id      = task_id;
		ctl.new_slot.arrival = task_arrival;
		ctl.new_slot.burst   = task_burst;
		ctl.new_slot.prio    = priority_req;
		// Drop inserts of the null id and inserts into a full queue.
		ctl.insert_en = in_fire && is_insert && (task_id != '0) && !full;
		// Drop removes from an empty queue.
		ctl.remove_en = in_fire && is_remove && !empty;
		ok = ctl.insert_en || ctl.remove_en || (in_fire && is_reorder);
		occ_d = occ_q;
		if (ctl.insert_en) begin
			occ_d = occ_q + W'(1);
		end else if (ctl.remove_en) begin
			occ_d = occ_q - W'(1);
		end
	end

	// Chain of cells, head at index 0. Each cell sees its front and rear neighbor.
	for (genvar k = 0; k < D; k++) begin : g_cell
		spq_pkg::slot_t prev_s;
		spq_pkg::slot_t next_s;
		logic           prev_gt;

		if (k == 0) begin : g_head
			assign prev_s  = ctl.new_slot;
			assign prev_gt = 1'b0;
		end else begin : g_body
			assign prev_s  = cell_q[k-1];
			assign prev_gt = cell_gt[k-1];
		end

		if (k == D - 1) begin : g_tail
			assign next_s = cell_q[k];
		end else begin : g_mid
			assign next_s = cell_q[k+1];
		end

		spq_cell u_cell (
			.clk          (clk),
			.ctl          (ctl),
			.occupied     (occ_q > W'(k)),
			.at_tail      (occ_q == W'(k)),
			.prev_greater (prev_gt),
			.prev_slot    (prev_s),
			.next_slot    (next_s),
			.new_greater  (cell_gt[k]),
			.slot_q       (cell_q[k]),
			.slot_d       (cell_d[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				occ_q       <= occ_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the result from the chain's next head value; zero it when empty.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			head_q  <= (occ_d == '0) ? '0 : cell_d[0];
			count_q <= 5'(occ_d);
			empty_q <= occ_d == '0;
			ok_q    <= ok;
		end
	end

	assign head_id       = head_q.id;
	assign head_arrival  = head_q.arrival;
	assign head_burst    = head_q.burst;
	assign head_priority = head_q.prio;
	assign entry_count   = count_q;
	assign queue_empty   = empty_q;
	assign accepted      = ok_q;

endmodule

// ===== rtl/spq_checker.sv =====
// Port-level checks of the sorted priority queue, bound to its top level.
// Depends on assert_macros.svh, spq_pkg and sorted_priority_queue_top.
`include "assert_macros.svh"

module spq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic        [1:0]  cmd,
	input logic               out_valid,
	input logic               out_ready,
	input logic        [15:0] head_id,
	input logic signed [31:0] head_priority,
	input logic        [4:0]  entry_count,
	input logic               queue_empty,
	input logic               accepted
);

	`SPQ_ASSERT_NEXT(a_result_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(head_id) && $stable(entry_count))
	`SPQ_ASSERT(a_stall_blocks_input, clk, arst_n, !(out_valid && !out_ready && in_ready))
	`SPQ_ASSERT(a_empty_flag, clk, arst_n, !out_valid || (queue_empty == (entry_count == 5'd0)))
	`SPQ_ASSERT(a_empty_head_zero, clk, arst_n, !(out_valid && queue_empty) || (head_id == 16'd0 && head_priority == 32'sd0))
	`SPQ_ASSERT_NEXT(a_reorder_accepted, clk, arst_n, in_valid && in_ready && cmd == spq_pkg::CMD_REORDER, out_valid && accepted)

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.cmd           (cmd),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.head_id       (head_id),
	.head_priority (head_priority),
	.entry_count   (entry_count),
	.queue_empty   (queue_empty),
	.accepted      (accepted)
);
